// ===== src/slfr_pkg.sv =====
// Shared types and constants for the sync/length frame receiver.
// Used by slfr_cfg, slfr_core and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package slfr_pkg;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [1:0] REG_SYNC_FIRST  = 2'd0;
  localparam logic [1:0] REG_SYNC_SECOND = 2'd1;
  localparam logic [1:0] REG_MAX_LEN     = 2'd2;
  localparam logic [1:0] REG_LOG_LIMIT   = 2'd3;

  localparam logic [7:0]  RST_SYNC_FIRST  = 8'd148;
  localparam logic [7:0]  RST_SYNC_SECOND = 8'd195;
  localparam logic [15:0] RST_MAX_LEN     = 16'd512;
  localparam logic [15:0] RST_LOG_LIMIT   = 16'd255;

  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_LOG_CHAR = 3'd1,
    KIND_LOG_END  = 3'd2,
    KIND_DROPPED  = 3'd3,
    KIND_EMPTY    = 3'd4
  } kind_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [15:0] max_payload_length;
    logic [15:0] log_line_limit;
  } cfg_t;

endpackage

`default_nettype wire

// ===== src/slfr_cfg.sv =====
// Configuration register file with an APB-style access port.
// Depends on slfr_pkg for register indexes, reset values and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module slfr_cfg
  import slfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [CFG_DATA_W-1:0] pwdata,
  output logic      [CFG_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg
);

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC_FIRST:  cfg_nxt.sync_first         = pwdata[7:0];
        REG_SYNC_SECOND: cfg_nxt.sync_second        = pwdata[7:0];
        REG_MAX_LEN:     cfg_nxt.max_payload_length = pwdata[15:0];
        REG_LOG_LIMIT:   cfg_nxt.log_line_limit     = pwdata[15:0];
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SYNC_FIRST:  prdata = {24'd0, cfg_r.sync_first};
      REG_SYNC_SECOND: prdata = {24'd0, cfg_r.sync_second};
      REG_MAX_LEN:     prdata = {16'd0, cfg_r.max_payload_length};
      REG_LOG_LIMIT:   prdata = {16'd0, cfg_r.log_line_limit};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_first         <= RST_SYNC_FIRST;
      cfg_r.sync_second        <= RST_SYNC_SECOND;
      cfg_r.max_payload_length <= RST_MAX_LEN;
      cfg_r.log_line_limit     <= RST_LOG_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/slfr_core.sv =====
// Deframer datapath: input register, per-byte parser state, result register.
// Depends on slfr_pkg for kind codes, character constants and cfg_t.
`timescale 1ns / 1ps
`default_nettype none

module slfr_core
  import slfr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cfg_t        cfg,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output kind_t            out_kind,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic [15:0]      out_length
);

  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_SYNC2   = 2'd1,
    PH_LENGTH  = 2'd2,
    PH_PAYLOAD = 2'd3
  } phase_t;

  // Input stage.
  logic        in_valid_r, in_valid_nxt;
  logic [7:0]  in_byte_r;

  // Parser state.
  phase_t      phase_r, phase_nxt;
  logic        len_lo_r, len_lo_nxt;   // high length byte already taken
  logic [15:0] length_r, length_nxt;
  logic [15:0] remain_r, remain_nxt;
  logic [15:0] log_cnt_r, log_cnt_nxt;

  // Result stage.
  logic        out_valid_r, out_valid_nxt;
  kind_t       kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic        last_r, last_nxt;
  logic [15:0] olen_r, olen_nxt;

  logic        adv;
  logic        fire;
  logic        res_valid;
  logic [15:0] len_asm;

  // The result register can be loaded when it is empty or being drained.
  assign adv      = !out_valid_r || out_ready;
  assign fire     = in_valid_r && adv;
  assign in_ready = !in_valid_r || adv;
  assign len_asm  = {length_r[7:0], in_byte_r};

  always_comb begin
    phase_nxt   = phase_r;
    len_lo_nxt  = len_lo_r;
    length_nxt  = length_r;
    remain_nxt  = remain_r;
    log_cnt_nxt = log_cnt_r;
    res_valid   = 1'b0;
    kind_nxt    = KIND_PAYLOAD;
    byte_nxt    = 8'd0;
    last_nxt    = 1'b0;
    olen_nxt    = 16'd0;
    if (fire) begin
      unique case (phase_r)
        PH_HUNT: begin
          // The first sync byte is never log text, even if it equals CR or LF.
          if (in_byte_r == cfg.sync_first) begin
            phase_nxt = PH_SYNC2;
          end else if (in_byte_r == CHAR_LF) begin
            log_cnt_nxt = 16'd0;
            res_valid   = 1'b1;
            kind_nxt    = KIND_LOG_END;
          end else if (in_byte_r != CHAR_CR && log_cnt_r < cfg.log_line_limit) begin
            log_cnt_nxt = log_cnt_r + 16'd1;
            res_valid   = 1'b1;
            kind_nxt    = KIND_LOG_CHAR;
            byte_nxt    = in_byte_r;
          end
        end
        PH_SYNC2: begin
          if (in_byte_r == cfg.sync_second) begin
            phase_nxt  = PH_LENGTH;
            len_lo_nxt = 1'b0;
            length_nxt = 16'd0;
          end else begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_LENGTH: begin
          length_nxt = len_asm;
          len_lo_nxt = 1'b1;
          if (len_lo_r) begin
            if (len_asm > cfg.max_payload_length) begin
              phase_nxt = PH_HUNT;
              res_valid = 1'b1;
              kind_nxt  = KIND_DROPPED;
              olen_nxt  = len_asm;
            end else if (len_asm == 16'd0) begin
              phase_nxt = PH_HUNT;
              res_valid = 1'b1;
              kind_nxt  = KIND_EMPTY;
              last_nxt  = 1'b1;
            end else begin
              remain_nxt = len_asm;
              phase_nxt  = PH_PAYLOAD;
            end
          end
        end
        PH_PAYLOAD: begin
          res_valid = 1'b1;
          kind_nxt  = KIND_PAYLOAD;
          byte_nxt  = in_byte_r;
          olen_nxt  = length_r;
          if (remain_r <= 16'd1) begin
            remain_nxt = 16'd0;
            last_nxt   = 1'b1;
            phase_nxt  = PH_HUNT;
          end else begin
            remain_nxt = remain_r - 16'd1;
          end
        end
        default: phase_nxt = PH_HUNT;
      endcase
    end
  end

  always_comb begin
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (fire) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
    if (fire) begin
      out_valid_nxt = res_valid;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      phase_r     <= PH_HUNT;
      len_lo_r    <= 1'b0;
      length_r    <= 16'd0;
      remain_r    <= 16'd0;
      log_cnt_r   <= 16'd0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      phase_r     <= phase_nxt;
      len_lo_r    <= len_lo_nxt;
      length_r    <= length_nxt;
      remain_r    <= remain_nxt;
      log_cnt_r   <= log_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (fire && res_valid) begin
      kind_r <= kind_nxt;
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      olen_r <= olen_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = kind_r;
  assign out_byte   = byte_r;
  assign out_last   = last_r;
  assign out_length = olen_r;

  // A payload phase always has at least one byte left to receive.
  a_payload_remain: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> remain_r != 16'd0)
    else $error("payload phase entered with nothing remaining");

  // The last payload byte of a frame sends the parser back to hunting.
  a_last_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && kind_nxt == KIND_PAYLOAD && last_nxt |=> phase_r == PH_HUNT)
    else $error("parser did not return to hunting after the last payload byte");

  // A log result never carries a frame length or a last flag.
  a_log_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (kind_r == KIND_LOG_CHAR || kind_r == KIND_LOG_END)
      |-> olen_r == 16'd0 && !last_r)
    else $error("log result carries frame fields");

  // A kept log character always leaves a nonzero line count behind.
  a_log_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fire && res_valid && kind_nxt == KIND_LOG_CHAR |=> log_cnt_r != 16'd0)
    else $error("log count not advanced on a kept character");

endmodule

`default_nettype wire

// ===== src/sync_length_frame_receiver.sv =====
// Top level of the two-byte sync, length-prefixed frame receiver with log path.
// Accepted bytes wait in the input register; results go out from the result register.
// Throughput: one item per cycle while the output side is ready; the parser state
// update is a single pass between the input register and the result register.
// Reset (rst_n, synchronous, active low) empties both registers, returns the parser to
// hunting with all counters at zero, and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module sync_length_frame_receiver
  import slfr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // Input stream.
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,    // [7:0] rx_byte
  // Result stream.
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [23:0]                out_tdata,   // [7:0] out_byte, [23:8] frame_length
  output logic                       out_tlast,   // frame_last
  output logic [2:0]                 out_tuser,   // [2:0] result_kind
  // Configuration port.
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic      [CFG_DATA_W-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  cfg_t        cfg;
  kind_t       kind;
  logic [7:0]  obyte;
  logic [15:0] olen;

  slfr_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  slfr_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (kind),
    .out_byte   (obyte),
    .out_last   (out_tlast),
    .out_length (olen)
  );

  assign out_tdata = {olen, obyte};
  assign out_tuser = kind;

endmodule

`default_nettype wire

// ===== bench/sync_length_frame_receiver_tb.sv =====
// Self-checking bench for the sync/length frame receiver: serial bytes in, payload, log-text,
// drop and empty-frame items out, checked against a behavioral parser kept in the bench.
// Depends on slfr_pkg and sync_length_frame_receiver from the source tree.
`timescale 1ns / 1ps

module sync_length_frame_receiver_tb;
  import slfr_pkg::*;

  typedef enum logic [1:0] {
    ST_HUNT    = 2'd0,
    ST_SYNC2   = 2'd1,
    ST_LENGTH  = 2'd2,
    ST_PAYLOAD = 2'd3
  } rx_state_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data;
    logic        last;
    logic [15:0] flen;
  } deframed_t;

  localparam logic [2:0] HEADER_BYTES = 3'd4;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;      // [7:0] rx_byte
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [23:0] out_tdata;         // [7:0] out_byte, [23:8] frame_length
  logic out_tlast;                // frame_last
  logic [2:0] out_tuser;          // [2:0] result_kind
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  sync_length_frame_receiver DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Register copies and parser state of the behavioral receiver.
  logic [7:0]  exp_sync_first = RST_SYNC_FIRST;
  logic [7:0]  exp_sync_second = RST_SYNC_SECOND;
  logic [15:0] exp_max_len = RST_MAX_LEN;
  logic [15:0] exp_log_limit = RST_LOG_LIMIT;
  rx_state_t   ps_state = ST_HUNT;
  logic [2:0]  ps_hdr_cnt = '0;
  logic [15:0] ps_len = '0;
  logic [15:0] ps_remaining = '0;
  logic [15:0] ps_log_count = '0;

  logic [7:0] rx_bytes_q[$];
  deframed_t  deframed_q[$];
  deframed_t  drv_res;
  deframed_t  mon_exp;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int errors = 0;
  int bytes_queued = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int kind_seen[5] = '{default: 0};

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** sync_length_frame_receiver: FAILED **");
    $finish;
  end

  // Parses one received byte and reports whether it yields an output item.
  function automatic bit deframe_byte(input logic [7:0] b, output deframed_t r);
    r = '0;
    case (ps_state)
      ST_HUNT: begin
        if (b == exp_sync_first) begin
          ps_state = ST_SYNC2;
          ps_hdr_cnt = 3'd1;
          return 1'b0;
        end
        if (b == CHAR_CR) return 1'b0;
        if (b == CHAR_LF) begin
          ps_log_count = '0;
          r.kind = KIND_LOG_END;
          return 1'b1;
        end
        if (ps_log_count < exp_log_limit) begin
          ps_log_count = ps_log_count + 16'd1;
          r.kind = KIND_LOG_CHAR;
          r.data = b;
          return 1'b1;
        end
        return 1'b0;
      end
      ST_SYNC2: begin
        if (b == exp_sync_second) begin
          ps_state = ST_LENGTH;
          ps_hdr_cnt = 3'd2;
          ps_len = '0;
        end else begin
          ps_state = ST_HUNT;
        end
        return 1'b0;
      end
      ST_LENGTH: begin
        ps_len = {ps_len[7:0], b};
        ps_hdr_cnt = ps_hdr_cnt + 3'd1;
        if (ps_hdr_cnt < HEADER_BYTES) return 1'b0;
        if (ps_len > exp_max_len) begin
          ps_state = ST_HUNT;
          r.kind = KIND_DROPPED;
          r.flen = ps_len;
          return 1'b1;
        end
        if (ps_len == 16'd0) begin
          ps_state = ST_HUNT;
          r.kind = KIND_EMPTY;
          r.last = 1'b1;
          return 1'b1;
        end
        ps_remaining = ps_len;
        ps_state = ST_PAYLOAD;
        return 1'b0;
      end
      default: begin
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.flen = ps_len;
        if (ps_remaining <= 16'd1) begin
          ps_remaining = '0;
          r.last = 1'b1;
          ps_state = ST_HUNT;
        end else begin
          ps_remaining = ps_remaining - 16'd1;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= MAX_REPORTS) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // Sender: holds an offered item until it is taken, otherwise offers the next byte
  // unless it decides to idle this cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      items_accepted++;
      if (deframe_byte(in_tdata, drv_res)) deframed_q.push_back(drv_res);
      if (rx_bytes_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tdata <= rx_bytes_q.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end else if (!in_tvalid) begin
      if (rx_bytes_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= rx_bytes_q.pop_front();
      end
    end
  end

  // Receiver: checks every taken result against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (deframed_q.size() == 0) begin
          flag_error($sformatf("unexpected item kind=%0d byte=%02h last=%0b len=%0d",
                               out_tuser, out_tdata[7:0], out_tlast, out_tdata[23:8]));
        end else begin
          mon_exp = deframed_q.pop_front();
          results_checked++;
          if (out_tuser !== mon_exp.kind || out_tdata[7:0] !== mon_exp.data ||
              out_tlast !== mon_exp.last || out_tdata[23:8] !== mon_exp.flen) begin
            flag_error($sformatf(
                "exp kind=%0d byte=%02h last=%0b len=%0d, got kind=%0d byte=%02h last=%0b len=%0d",
                mon_exp.kind, mon_exp.data, mon_exp.last, mon_exp.flen,
                out_tuser, out_tdata[7:0], out_tlast, out_tdata[23:8]));
          end else begin
            kind_seen[mon_exp.kind]++;
          end
        end
      end
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Writes a register with random junk above its width, which the block must ignore.
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    logic [31:0] junk;
    logic [31:0] wdata;
    junk = $urandom;
    if (idx == REG_SYNC_FIRST || idx == REG_SYNC_SECOND) wdata = {junk[31:8], val[7:0]};
    else wdata = {junk[31:16], val};
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_SYNC_FIRST:  exp_sync_first = val[7:0];
      REG_SYNC_SECOND: exp_sync_second = val[7:0];
      REG_MAX_LEN:     exp_max_len = val;
      default:         exp_log_limit = val;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b);
    rx_bytes_q.push_back(b);
    bytes_queued++;
  endtask

  // A well-formed frame; the payload is only sent when the length will be accepted.
  task automatic send_frame(input logic [15:0] len);
    send_byte(exp_sync_first);
    send_byte(exp_sync_second);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len != 0 && len <= exp_max_len) repeat (len) send_byte($urandom_range(255, 0));
  endtask

  // Also covers a header byte that may still be in flight with no result.
  task automatic wait_drained();
    while (rx_bytes_q.size() != 0 || in_tvalid || deframed_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic send_random(input int n);
    int stop_at;
    int sel;
    int cnt;
    logic [7:0] c;
    logic [15:0] len;
    stop_at = bytes_queued + n;
    while (bytes_queued < stop_at) begin
      sel = $urandom_range(99, 0);
      if (sel < 35) begin
        // Log line, sometimes longer than the line limit, with stray carriage returns.
        cnt = $urandom_range((exp_log_limit > 6) ? 8 : exp_log_limit + 2, 0);
        repeat (cnt) begin
          do c = $urandom_range(255, 0); while (c == exp_sync_first || c == CHAR_LF);
          send_byte(c);
          if ($urandom_range(9, 0) == 0) send_byte(CHAR_CR);
        end
        send_byte(CHAR_LF);
      end else if (sel < 75) begin
        cnt = $urandom_range(99, 0);
        if (cnt < 15 && exp_max_len != 16'hFFFF)
          len = $urandom_range(65535, exp_max_len + 1);
        else if (cnt < 30)
          len = $urandom_range((exp_max_len > 64) ? 64 : exp_max_len, 0);
        else
          len = $urandom_range((exp_max_len > 12) ? 12 : exp_max_len, 0);
        send_frame(len);
      end else if (sel < 88) begin
        // First sync byte followed by a wrong second byte.
        c = $urandom_range(255, 0);
        if (c == exp_sync_second) c = c + 8'd1;
        send_byte(exp_sync_first);
        send_byte(c);
      end else begin
        repeat ($urandom_range(3, 1)) send_byte($urandom_range(255, 0));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset register values; sender idles lightly, receiver heavily.
    send_idle_pct = 26;
    recv_idle_pct = 69;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_frame(16'd0);
    send_frame(16'd1);
    send_frame(16'hFFFF);
    send_byte(exp_sync_first);
    send_byte(CHAR_LF);          // wrong second byte, must not end a log line
    send_frame(16'd2);
    send_random(120);
    wait_drained();

    // Sync bytes equal to the line controls, no payload allowed, every log char dropped.
    send_idle_pct = 69;
    recv_idle_pct = 26;
    write_reg(REG_SYNC_FIRST, CHAR_LF);
    write_reg(REG_SYNC_SECOND, CHAR_CR);
    write_reg(REG_MAX_LEN, 16'd0);
    write_reg(REG_LOG_LIMIT, 16'd0);
    send_frame(16'd0);
    send_frame(16'd1);
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    send_byte(8'h41);
    send_byte(8'h78);
    send_random(80);
    wait_drained();

    write_reg(REG_SYNC_FIRST, 8'h00);
    write_reg(REG_SYNC_SECOND, 8'hFF);
    write_reg(REG_MAX_LEN, 16'hFFFF);
    write_reg(REG_LOG_LIMIT, 16'hFFFF);
    send_random(100);
    wait_drained();

    // No idling. A log line overflows and keeps its count across a frame.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_SYNC_FIRST, 8'hFF);
    write_reg(REG_SYNC_SECOND, 8'h00);
    write_reg(REG_MAX_LEN, 16'd20);
    write_reg(REG_LOG_LIMIT, 16'd3);
    send_byte(8'h61);
    send_byte(8'h62);
    send_byte(8'h63);
    send_byte(8'h64);
    send_frame(16'd1);
    send_byte(8'h65);
    send_byte(CHAR_LF);
    send_byte(8'h67);
    send_frame(16'd21);
    wait_drained();

    // The receiver stalls long enough for the block to back up onto its input.
    hold_requests++;
    send_frame(16'd20);
    send_frame(16'd20);
    wait_drained();
    send_random(150);
    wait_drained();
    repeat (20) @(posedge clk);

    if (deframed_q.size() != 0)
      flag_error($sformatf("%0d expected items never arrived", deframed_q.size()));
    $display("Checked %0d output items from %0d input bytes over four register settings.",
             results_checked, items_accepted);
    $display("Payload %0d, log chars %0d, line ends %0d, oversize drops %0d, empty frames %0d.",
             kind_seen[KIND_PAYLOAD], kind_seen[KIND_LOG_CHAR], kind_seen[KIND_LOG_END],
             kind_seen[KIND_DROPPED], kind_seen[KIND_EMPTY]);
    if (errors == 0) begin
      $display("** sync_length_frame_receiver: PASSED **");
    end else begin
      $display("** sync_length_frame_receiver: FAILED **");
    end
    $finish;
  end

endmodule
